// ----- design/prc_pkg.sv -----
// Package with widths, types and register indexes of the proportional-resonant controller.
`default_nettype none

package prc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 32;
    localparam int RES_W     = 32;
    localparam int ERR_W     = SAMPLE_W + 1;
    localparam int COEF_FRAC = COEF_W - 8;
    localparam int PRE_SHIFT = 8;
    localparam int RND_SHIFT = COEF_FRAC - PRE_SHIFT;

    localparam int PROD_E_W  = COEF_W + ERR_W;
    localparam int PROD_Y_W  = COEF_W + RES_W;
    localparam int ACC_W     = PROD_Y_W - PRE_SHIFT + 2;
    localparam int RND_W     = ACC_W - RND_SHIFT;
    localparam int P_W       = PROD_E_W - COEF_FRAC;
    localparam int SUM_W     = ((P_W > RES_W) ? P_W : RES_W) + 1;

    localparam int S_TDATA_W = ((2 * SAMPLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = (COEF_W > SAMPLE_W) ? COEF_W : SAMPLE_W;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [ERR_W-1:0]    t_err;
    typedef logic signed [RES_W-1:0]    t_res;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;

    localparam t_cfg_idx CFG_PROP_GAIN     = 3'd0;
    localparam t_cfg_idx CFG_NUM_COEF_ZERO = 3'd1;
    localparam t_cfg_idx CFG_NUM_COEF_TWO  = 3'd2;
    localparam t_cfg_idx CFG_DEN_COEF_ONE  = 3'd3;
    localparam t_cfg_idx CFG_DEN_COEF_TWO  = 3'd4;
    localparam t_cfg_idx CFG_DRIVE_FLOOR   = 3'd5;
    localparam t_cfg_idx CFG_DRIVE_CEILING = 3'd6;

    localparam t_sample SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

endpackage

`default_nettype wire

// ----- design/proportional_resonant_controller.sv -----
// Proportional-resonant controller with a saturating resonant section and a clamped drive output.
`default_nettype none

// Each transfer on the input stream carries a reference and a measured sample; the block
// returns one clamped drive sample per transfer. One transfer is taken every cycle unless the
// output stalls: the error is formed into an input register, and the proportional product,
// the four resonant products, their rounded and saturated sum and the output clamp are formed
// combinationally into the result register, since the resonant history feeds back through
// the previous-output multiplier from one sample to the next. Coefficients must be written
// through the register port while no sample is in flight; the block does not enforce this.
module proportional_resonant_controller
    import prc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire t_cfg_idx             i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // Fields from bit 0 up: ref_sample, meas_sample.
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // Fields from bit 0 up: clear_history.
    input  wire logic                 s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // Fields from bit 0 up: drive.
    output logic [M_TDATA_W-1:0]      m_axis_tdata,
    // Fields from bit 0 up: limited.
    output logic                      m_axis_tuser
);

    localparam logic signed [PROD_E_W-1:0] P_HALF   = PROD_E_W'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [ACC_W-1:0]    ACC_HALF = ACC_W'(1) <<< (RND_SHIFT - 1);
    localparam logic signed [RND_W-1:0]    RND_MAX  =
        {{(RND_W-RES_W){1'b0}}, 1'b0, {(RES_W-1){1'b1}}};
    localparam logic signed [RND_W-1:0]    RND_MIN  =
        {{(RND_W-RES_W){1'b1}}, 1'b1, {(RES_W-1){1'b0}}};

    t_coef   r_kp, r_b0, r_b2, r_a1, r_a2;
    t_sample r_floor, r_ceiling;

    logic    r_in_valid;
    t_err    r_in_err;
    logic    r_in_clr;

    t_err    r_err_one, r_err_two;
    t_res    r_res_one, r_res_two;

    logic                  r_out_valid;
    t_sample               r_out_drive;
    logic                  r_out_limited;

    logic                  out_free;
    logic                  fire;
    t_sample               in_ref, in_meas;
    t_err                  n_in_err;
    t_err                  err_two_used;
    t_res                  res_one_used, res_two_used;
    logic signed [PROD_E_W-1:0] prod_p, prod_b0, prod_b2, p_rnd;
    logic signed [PROD_Y_W-1:0] prod_a1, prod_a2;
    logic signed [ACC_W-1:0]    acc, acc_rnd;
    logic signed [RND_W-1:0]    res_rnd;
    t_res                  n_res;
    logic signed [P_W-1:0]      p_term;
    logic signed [SUM_W-1:0]    sum, sum_hi, sum_lo, clamp1, clamp2;
    logic                  n_limited;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    assign in_ref   = t_sample'(s_axis_tdata[SAMPLE_W-1:0]);
    assign in_meas  = t_sample'(s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]);
    assign n_in_err = ERR_W'(in_ref) - ERR_W'(in_meas);

    always_comb begin
        err_two_used = r_in_clr ? '0 : r_err_two;
        res_one_used = r_in_clr ? '0 : r_res_one;
        res_two_used = r_in_clr ? '0 : r_res_two;

        prod_p  = PROD_E_W'(r_kp) * PROD_E_W'(r_in_err);
        prod_b0 = PROD_E_W'(r_b0) * PROD_E_W'(r_in_err);
        prod_b2 = PROD_E_W'(r_b2) * PROD_E_W'(err_two_used);
        prod_a1 = PROD_Y_W'(r_a1) * PROD_Y_W'(res_one_used);
        prod_a2 = PROD_Y_W'(r_a2) * PROD_Y_W'(res_two_used);

        p_rnd  = prod_p + P_HALF;
        p_term = P_W'(p_rnd >>> COEF_FRAC);

        acc = ACC_W'(prod_b0 >>> PRE_SHIFT) + ACC_W'(prod_b2 >>> PRE_SHIFT)
            - ACC_W'(prod_a1 >>> PRE_SHIFT) - ACC_W'(prod_a2 >>> PRE_SHIFT);
        acc_rnd = acc + ACC_HALF;
        res_rnd = RND_W'(acc_rnd >>> RND_SHIFT);

        if (res_rnd > RND_MAX) begin
            n_res = RES_W'(RND_MAX);
        end else if (res_rnd < RND_MIN) begin
            n_res = RES_W'(RND_MIN);
        end else begin
            n_res = RES_W'(res_rnd);
        end

        sum    = SUM_W'(p_term) + SUM_W'(n_res);
        sum_hi = SUM_W'(r_ceiling);
        sum_lo = SUM_W'(r_floor);
        n_limited = 1'b0;
        clamp1 = sum;
        if (sum > sum_hi) begin
            clamp1    = sum_hi;
            n_limited = 1'b1;
        end
        clamp2 = clamp1;
        if (clamp1 < sum_lo) begin
            clamp2    = sum_lo;
            n_limited = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp      <= '0;
            r_b0      <= '0;
            r_b2      <= '0;
            r_a1      <= '0;
            r_a2      <= '0;
            r_floor   <= '0;
            r_ceiling <= SAMPLE_MAX;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PROP_GAIN:     r_kp      <= t_coef'(i_cfg_data[COEF_W-1:0]);
                CFG_NUM_COEF_ZERO: r_b0      <= t_coef'(i_cfg_data[COEF_W-1:0]);
                CFG_NUM_COEF_TWO:  r_b2      <= t_coef'(i_cfg_data[COEF_W-1:0]);
                CFG_DEN_COEF_ONE:  r_a1      <= t_coef'(i_cfg_data[COEF_W-1:0]);
                CFG_DEN_COEF_TWO:  r_a2      <= t_coef'(i_cfg_data[COEF_W-1:0]);
                CFG_DRIVE_FLOOR:   r_floor   <= t_sample'(i_cfg_data[SAMPLE_W-1:0]);
                CFG_DRIVE_CEILING: r_ceiling <= t_sample'(i_cfg_data[SAMPLE_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_err <= n_in_err;
            r_in_clr <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_one <= '0;
            r_err_two <= '0;
            r_res_one <= '0;
            r_res_two <= '0;
        end else if (fire) begin
            r_err_two <= r_in_clr ? '0 : r_err_one;
            r_err_one <= r_in_err;
            r_res_two <= res_one_used;
            r_res_one <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_drive   <= t_sample'(clamp2[SAMPLE_W-1:0]);
            r_out_limited <= n_limited;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(unsigned'(r_out_drive));
    assign m_axis_tuser  = r_out_limited;

    a_clear_zeroes_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in_clr |=> r_err_two == '0 && r_res_two == '0)
        else $error("history not cleared after a clearing sample");

    a_error_shifts_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_err_one == $past(r_in_err) && r_res_two == $past(res_one_used))
        else $error("history did not advance with the processed sample");

    a_ready_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_out_valid && !m_axis_tready)
        else $error("input stalled without a blocked pipeline");

    a_result_follows_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("processed sample produced no result");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking stream testbench for the proportional-resonant controller.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import prc_pkg::*;

    localparam int MAX_GAP      = 17;
    localparam int STALL_CYCLES = 500;
    localparam int IDLE_LIMIT   = 5000;
    localparam int MAX_REPORTS  = 10;
    localparam int N_PHASES     = 8;
    localparam int PHASE_ITEMS  = 250;

    localparam t_cfg_idx CFG_UNUSED = 3'd7;

    localparam t_sample SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam t_coef   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};
    localparam t_coef   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
    localparam t_coef   COEF_ONE   = t_coef'(1) <<< COEF_FRAC;
    localparam longint  RES_HI     = 64'sd2147483647;
    localparam longint  RES_LO     = -64'sd2147483648;

    localparam t_sample EXTREMES [5] = '{SAMPLE_MIN, -16'sd1, 16'sd0, 16'sd1, SAMPLE_MAX};
    localparam t_coef   COEF_EXTREMES [4] = '{COEF_MIN, COEF_MAX, 32'sd0, COEF_ONE};

    typedef struct packed {
        logic    clr;
        t_sample feedback;
        t_sample setpoint;
    } sample_item_t;

    typedef struct packed {
        logic    limited;
        t_sample drive;
    } drive_item_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    t_cfg_idx             i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    sample_item_t sample_pending [$];
    drive_item_t  drive_expected [$];
    sample_item_t tx_item;

    t_coef   gain_kp, coef_b0, coef_b2, coef_a1, coef_a2;
    t_sample drive_lo, drive_hi;
    longint  err_z1, err_z2, res_z1, res_z2;

    int   n_queued = 0;
    int   n_accepted = 0;
    int   n_failures = 0;
    int   idle_cycles = 0;
    int   tx_gap = 0;
    int   rx_gap = 0;
    int   rx_hold = 0;
    int   rx_stall_token = 0;
    int   rx_stall_seen = 0;
    logic tx_idle_on = 1'b0;
    logic rx_idle_on = 1'b0;

    proportional_resonant_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void log_failure(string msg);
        n_failures++;
        if (n_failures <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endfunction

    function automatic drive_item_t controller_step(sample_item_t x);
        longint      err, prop, acc, res, sum;
        drive_item_t y;
        if (x.clr) begin
            err_z1 = 0;
            err_z2 = 0;
            res_z1 = 0;
            res_z2 = 0;
        end
        err = longint'($signed(x.setpoint)) - longint'($signed(x.feedback));
        prop = (longint'(gain_kp) * err + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
        acc = ((longint'(coef_b0) * err) >>> PRE_SHIFT)
            + ((longint'(coef_b2) * err_z2) >>> PRE_SHIFT)
            - ((longint'(coef_a1) * res_z1) >>> PRE_SHIFT)
            - ((longint'(coef_a2) * res_z2) >>> PRE_SHIFT);
        res = (acc + (longint'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
        if (res > RES_HI) begin
            res = RES_HI;
        end else if (res < RES_LO) begin
            res = RES_LO;
        end
        err_z2 = err_z1;
        err_z1 = err;
        res_z2 = res_z1;
        res_z1 = res;
        sum = prop + res;
        y.limited = 1'b0;
        if (sum > longint'(drive_hi)) begin
            sum = longint'(drive_hi);
            y.limited = 1'b1;
        end
        if (sum < longint'(drive_lo)) begin
            sum = longint'(drive_lo);
            y.limited = 1'b1;
        end
        y.drive = t_sample'(sum);
        return y;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            gain_kp  <= '0;
            coef_b0  <= '0;
            coef_b2  <= '0;
            coef_a1  <= '0;
            coef_a2  <= '0;
            drive_lo <= '0;
            drive_hi <= SAMPLE_MAX;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PROP_GAIN:     gain_kp  <= i_cfg_data[COEF_W-1:0];
                CFG_NUM_COEF_ZERO: coef_b0  <= i_cfg_data[COEF_W-1:0];
                CFG_NUM_COEF_TWO:  coef_b2  <= i_cfg_data[COEF_W-1:0];
                CFG_DEN_COEF_ONE:  coef_a1  <= i_cfg_data[COEF_W-1:0];
                CFG_DEN_COEF_TWO:  coef_a2  <= i_cfg_data[COEF_W-1:0];
                CFG_DRIVE_FLOOR:   drive_lo <= i_cfg_data[SAMPLE_W-1:0];
                CFG_DRIVE_CEILING: drive_hi <= i_cfg_data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always @(posedge i_clk) begin
        logic vld_next;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            err_z1 = 0;
            err_z2 = 0;
            res_z1 = 0;
            res_z2 = 0;
            tx_gap = 0;
        end else begin
            vld_next = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                drive_expected.push_back(controller_step(tx_item));
                n_accepted++;
                vld_next = 1'b0;
                tx_gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (!vld_next) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (sample_pending.size() > 0) begin
                    tx_item = sample_pending.pop_front();
                    s_axis_tdata <= {tx_item.feedback, tx_item.setpoint};
                    s_axis_tuser <= tx_item.clr;
                    vld_next = 1'b1;
                end
            end
            s_axis_tvalid <= vld_next;
        end
    end

    always @(posedge i_clk) begin
        logic        rdy_next;
        drive_item_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_gap = 0;
            rx_hold = 0;
        end else begin
            rdy_next = m_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                if (drive_expected.size() == 0) begin
                    log_failure($sformatf("result drive=%0d with no transfer pending",
                                          $signed(m_axis_tdata[SAMPLE_W-1:0])));
                end else begin
                    want = drive_expected.pop_front();
                    if (m_axis_tdata[SAMPLE_W-1:0] !== want.drive) begin
                        log_failure($sformatf("drive expected %0d, got %0d", want.drive,
                                              $signed(m_axis_tdata[SAMPLE_W-1:0])));
                    end
                    if (m_axis_tuser !== want.limited) begin
                        log_failure($sformatf("limited expected %0b, got %0b",
                                              want.limited, m_axis_tuser));
                    end
                end
                rdy_next = 1'b0;
                rx_gap = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (rx_stall_token != rx_stall_seen) begin
                rx_stall_seen = rx_stall_token;
                rx_hold = STALL_CYCLES;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                rdy_next = 1'b0;
            end else if (!rdy_next) begin
                if (rx_gap > 0) begin
                    rx_gap--;
                end else begin
                    rdy_next = 1'b1;
                end
            end
            m_axis_tready <= rdy_next;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles.", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_sample(t_sample setpoint, t_sample feedback, logic clr);
        sample_item_t item;
        item.setpoint = setpoint;
        item.feedback = feedback;
        item.clr = clr;
        sample_pending.push_back(item);
        n_queued++;
    endtask

    task automatic queue_random_samples(int count);
        t_sample     sp, fb;
        int unsigned mode;
        repeat (count) begin
            mode = $urandom_range(0, 9);
            if (mode < 6) begin
                sp = t_sample'($urandom());
                fb = t_sample'($urandom());
            end else if (mode < 9) begin
                sp = t_sample'($urandom());
                fb = sp + t_sample'($urandom_range(0, 64)) - 16'sd32;
            end else begin
                sp = EXTREMES[$urandom_range(0, 4)];
                fb = EXTREMES[$urandom_range(0, 4)];
            end
            queue_sample(sp, fb, $urandom_range(0, 19) == 0);
        end
    endtask

    task automatic wait_drained();
        while (n_accepted != n_queued || drive_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DAT_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    // The upper data bits of the clamp registers carry random junk that must be ignored.
    task automatic load_settings(t_coef kp, t_coef b0, t_coef b2, t_coef a1, t_coef a2,
                                 t_sample lo, t_sample hi);
        logic [CFG_DAT_W-1:0] lo_word, hi_word;
        lo_word = $urandom();
        hi_word = $urandom();
        lo_word[SAMPLE_W-1:0] = lo;
        hi_word[SAMPLE_W-1:0] = hi;
        write_reg(CFG_UNUSED, $urandom());
        write_reg(CFG_PROP_GAIN, kp);
        write_reg(CFG_NUM_COEF_ZERO, b0);
        write_reg(CFG_NUM_COEF_TWO, b2);
        write_reg(CFG_DEN_COEF_ONE, a1);
        write_reg(CFG_DEN_COEF_TWO, a2);
        write_reg(CFG_DRIVE_FLOOR, lo_word);
        write_reg(CFG_DRIVE_CEILING, hi_word);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int    d1, d2;
        t_coef kp, b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: zero gains, output held at zero.
        queue_sample(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        queue_sample(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        queue_sample(16'sd0, 16'sd0, 1'b1);
        wait_drained();

        load_settings(COEF_ONE, COEF_ONE, -COEF_ONE, '0, '0, SAMPLE_MIN, SAMPLE_MAX);
        queue_sample(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        queue_sample(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        queue_sample(16'sd1, 16'sd0, 1'b0);
        queue_sample(16'sd100, -16'sd100, 1'b0);
        queue_sample(16'sd0, 16'sd0, 1'b1);
        queue_sample(16'sd5, 16'sd3, 1'b0);
        wait_drained();

        // Resonant section driven into saturation, then cleared.
        load_settings('0, COEF_MAX, '0, COEF_MIN, COEF_MAX, SAMPLE_MIN, SAMPLE_MAX);
        repeat (4) queue_sample(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        queue_sample(16'sd0, 16'sd0, 1'b1);
        queue_sample(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        queue_sample(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        wait_drained();

        // Floor above ceiling.
        load_settings(COEF_ONE, '0, '0, '0, '0, 16'sd1000, -16'sd1000);
        queue_sample(16'sd0, 16'sd0, 1'b0);
        queue_sample(SAMPLE_MAX, 16'sd0, 1'b0);
        queue_sample(SAMPLE_MIN, 16'sd0, 1'b0);
        wait_drained();

        // Rounding of the proportional term at half a step.
        load_settings(COEF_ONE >>> 1, '0, '0, '0, '0, SAMPLE_MIN, SAMPLE_MAX);
        queue_sample(16'sd1, 16'sd0, 1'b0);
        queue_sample(16'sd0, 16'sd1, 1'b0);
        queue_sample(16'sd3, 16'sd0, 1'b0);
        wait_drained();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph % 3)
                0: begin
                    load_settings($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                                  t_sample'($urandom()), t_sample'($urandom()));
                end
                1: begin
                    d1 = $urandom_range(1 << 19, 1 << 21);
                    d2 = $urandom_range(0, 1 << 18);
                    kp = int'($urandom_range(0, 1 << 26)) - (1 << 25);
                    b0 = int'($urandom_range(0, 1 << 21)) - (1 << 20);
                    load_settings(kp, b0, -b0, -(2 * COEF_ONE - d1), COEF_ONE - d2,
                                  t_sample'(-int'($urandom_range(1000, 32768))),
                                  t_sample'($urandom_range(1000, 32767)));
                end
                default: begin
                    load_settings(COEF_EXTREMES[$urandom_range(0, 3)],
                                  COEF_EXTREMES[$urandom_range(0, 3)],
                                  COEF_EXTREMES[$urandom_range(0, 3)],
                                  COEF_EXTREMES[$urandom_range(0, 3)],
                                  COEF_EXTREMES[$urandom_range(0, 3)],
                                  EXTREMES[$urandom_range(0, 4)],
                                  EXTREMES[$urandom_range(0, 4)]);
                end
            endcase
            tx_idle_on <= ph[0];
            rx_idle_on <= ph[1];
            if (ph == 2) begin
                // Receiver holds off while the sender keeps offering, so the block backs up.
                rx_stall_token <= rx_stall_token + 1;
                queue_random_samples(PHASE_ITEMS);
            end else if (ph == 5) begin
                queue_random_samples(PHASE_ITEMS / 2);
                wait_drained();
                queue_random_samples(PHASE_ITEMS / 2);
            end else begin
                queue_random_samples(PHASE_ITEMS);
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (drive_expected.size() != 0) begin
            log_failure($sformatf("%0d results never arrived", drive_expected.size()));
        end
        if (n_failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
